FILE: hw/rtl/hbcd_pkg.sv
// Package for the HTTP body chunk deframer: codes, constants, state and result types.
// Used by hbcd_cfg, hbcd_step and http_body_chunk_deframer_unit.
// Depends on nothing else.
package hbcd_pkg;

  // Widths of the fields.
  localparam int unsigned CountW  = 31;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned StatusW = 2;

  // Saturation value of sizes and counts.
  localparam logic [CountW-1:0] Max31 = 31'h7FFF_FFFF;

  // Until-close store limit and size line digit limit.
  localparam logic [CountW-1:0] BodyLimit    = 31'd1048576;
  localparam logic [DigitW-1:0] MaxHexDigits = 4'd15;

  // Body framing modes; the unused code behaves as until-close.
  localparam logic [ModeW-1:0] ModeFixed   = 2'd0;
  localparam logic [ModeW-1:0] ModeChunked = 2'd1;
  localparam logic [ModeW-1:0] ModeClose   = 2'd2;

  // Status codes of a result item.
  localparam logic [StatusW-1:0] StNeedMore = 2'd0;
  localparam logic [StatusW-1:0] StComplete = 2'd1;
  localparam logic [StatusW-1:0] StNoBody   = 2'd2;
  localparam logic [StatusW-1:0] StSizeErr  = 2'd3;

  // Register indexes (word address bit 2).
  localparam logic RegMode   = 1'b0;
  localparam logic RegLength = 1'b1;

  // Characters of interest on the size line.
  localparam logic [ByteW-1:0] ChCr   = 8'h0D;
  localparam logic [ByteW-1:0] ChLf   = 8'h0A;
  localparam logic [ByteW-1:0] ChSemi = 8'h3B;

  // Parser phases.
  typedef enum logic [2:0] {
    PH_SIZE    = 3'd0,
    PH_EXT     = 3'd1,
    PH_SIZE_CR = 3'd2,
    PH_DATA    = 3'd3,
    PH_TAIL    = 3'd4,
    PH_TAIL_CR = 3'd5,
    PH_DONE    = 3'd6,
    PH_ERR     = 3'd7
  } phase_e;

  // Per-message parser state.
  typedef struct packed {
    phase_e             phase;
    logic [CountW-1:0]  size_rem;
    logic [DigitW-1:0]  digit_cnt;
    logic [CountW-1:0]  bytes_passed;
    logic               done;
  } state_t;

  // Configuration register contents.
  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic [CountW-1:0] length;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic               payload_valid;
    logic [ByteW-1:0]   payload_byte;
    logic [StatusW-1:0] status;
    logic [CountW-1:0]  payload_count;
  } result_t;

  // Hex digit decode: bit 4 marks a valid digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_value(input logic [ByteW-1:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/http_body_chunk_deframer_unit.sv
// HTTP body deframer unit: input register, parser state, result register.
// Usage:
//   Body bytes enter on the s_axis stream, one item per byte; tuser set starts a new
//   message and clears the parser state (its result is all zero). Each accepted item
//   yields exactly one result item on the m_axis stream: a payload flag in tuser and
//   the payload byte, status and running payload count in tdata.
//   The APB port sets the framing mode (address 0) and the fixed body length
//   (address 4); write it only while no items are in flight.
//   An accepted item waits in the input register until the result register is free;
//   its result is then registered there and offered on the m_axis stream.
//   Throughput is one item per cycle while the receiver takes results: the state update
//   is a single pass of short logic between the input register and the result register.
//   When the receiver stalls, the result register holds and the input register
//   takes one more item; after that s_axis_tready_o falls until the result drains.
//   Reset clears both registers' valid flags, the parser state and the
//   configuration (fixed-length mode, length zero).
// Depends on hbcd_pkg, hbcd_cfg and hbcd_step.
module http_body_chunk_deframer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] cmd
  // Result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // [7:0] payload_byte, [9:8] status,
                                        // [40:10] payload_count, [47:41] zero
  output logic        m_axis_tuser_o,   // [0] payload_valid
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  hbcd_pkg::cfg_t      cfg;
  hbcd_pkg::state_t    state_q, state_d;
  hbcd_pkg::result_t   res_d, res_q;
  logic                in_vld_q;
  logic                in_cmd_q;
  logic [7:0]          in_byte_q;
  logic                out_vld_q;
  logic                adv;

  hbcd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  hbcd_step u_step (
    .cmd_i    (in_cmd_q),
    .byte_i   (in_byte_q),
    .cfg_i    (cfg),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // The held item moves on when the result register is empty or being emptied.
  assign adv             = in_vld_q & (~out_vld_q | m_axis_tready_i);
  assign s_axis_tready_o = ~in_vld_q | adv;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_cmd_q  <= s_axis_tuser_i;
      in_byte_q <= s_axis_tdata_i;
    end
  end

  // Parser state and result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= '{phase: hbcd_pkg::PH_SIZE, default: '0};
      out_vld_q <= 1'b0;
    end else if (adv) begin
      state_q   <= state_d;
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = res_q.payload_valid;
  assign m_axis_tdata_o  = {7'd0, res_q.payload_count, res_q.status, res_q.payload_byte};

endmodule

FILE: hw/rtl/hbcd_cfg.sv
// APB-style configuration registers of the deframer: body mode and body length.
// Depends on hbcd_pkg.
module hbcd_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output hbcd_pkg::cfg_t      cfg_o
);

  hbcd_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  // Register write decode on the word address.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[2])
        hbcd_pkg::RegMode:   cfg_d.mode   = pwdata[hbcd_pkg::ModeW-1:0];
        hbcd_pkg::RegLength: cfg_d.length = pwdata[hbcd_pkg::CountW-1:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back.
  always_comb begin
    case (paddr[2])
      hbcd_pkg::RegMode:   prdata = {30'd0, cfg_q.mode};
      hbcd_pkg::RegLength: prdata = {1'b0, cfg_q.length};
      default:             prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/hbcd_step.sv
// Per-item next-state and result logic of the deframer for all three framing modes.
// Depends on hbcd_pkg.
module hbcd_step (
  input  logic                       cmd_i,
  input  logic [hbcd_pkg::ByteW-1:0] byte_i,
  input  hbcd_pkg::cfg_t             cfg_i,
  input  hbcd_pkg::state_t           state_i,
  output hbcd_pkg::state_t           state_o,
  output hbcd_pkg::result_t          result_o
);

  logic [4:0] hv;

  assign hv = hbcd_pkg::hex_value(byte_i);

  always_comb begin
    hbcd_pkg::phase_e             ph;
    logic                         fin;
    logic                         eol;
    logic                         by_cr;
    logic [hbcd_pkg::CountW-1:0]  bp_inc;
    hbcd_pkg::state_t             nxt;
    hbcd_pkg::result_t            res;

    nxt    = state_i;
    res    = '0;
    ph     = state_i.phase;
    fin    = 1'b0;
    eol    = 1'b0;
    by_cr  = 1'b0;
    bp_inc = state_i.bytes_passed + 31'd1;

    if (cmd_i) begin
      // New message: clear everything, registers are kept.
      nxt.phase        = hbcd_pkg::PH_SIZE;
      nxt.size_rem     = '0;
      nxt.digit_cnt    = '0;
      nxt.bytes_passed = '0;
      nxt.done         = 1'b0;
    end else if (state_i.done) begin
      res.status = hbcd_pkg::StComplete;
    end else if (cfg_i.mode == hbcd_pkg::ModeChunked) begin
      // Phases that may hand the byte on to a later phase.
      if (ph == hbcd_pkg::PH_SIZE_CR) begin
        if (byte_i == hbcd_pkg::ChLf) begin
          nxt.phase = hbcd_pkg::PH_DATA;
          fin       = 1'b1;
        end else begin
          ph = hbcd_pkg::PH_DATA;
        end
      end
      if (!fin && ph == hbcd_pkg::PH_DATA) begin
        if (state_i.size_rem != '0) begin
          res.payload_valid = 1'b1;
          if (state_i.bytes_passed != hbcd_pkg::Max31) begin
            nxt.bytes_passed = bp_inc;
          end
          nxt.size_rem = state_i.size_rem - 31'd1;
          nxt.phase    = (state_i.size_rem == 31'd1) ? hbcd_pkg::PH_TAIL : hbcd_pkg::PH_DATA;
          fin          = 1'b1;
        end else begin
          ph = hbcd_pkg::PH_TAIL;
        end
      end
      if (!fin && ph == hbcd_pkg::PH_TAIL) begin
        if (byte_i == hbcd_pkg::ChCr) begin
          nxt.phase = hbcd_pkg::PH_TAIL_CR;
          fin       = 1'b1;
        end else if (byte_i == hbcd_pkg::ChLf) begin
          nxt.phase = hbcd_pkg::PH_SIZE;
          fin       = 1'b1;
        end else begin
          ph = hbcd_pkg::PH_SIZE;
        end
      end
      if (!fin && ph == hbcd_pkg::PH_TAIL_CR) begin
        if (byte_i == hbcd_pkg::ChLf) begin
          nxt.phase = hbcd_pkg::PH_SIZE;
          fin       = 1'b1;
        end else begin
          ph = hbcd_pkg::PH_SIZE;
        end
      end
      // Phases that consume the byte for good.
      if (!fin) begin
        nxt.phase = ph;
        case (ph)
          hbcd_pkg::PH_SIZE: begin
            if (byte_i == hbcd_pkg::ChCr) begin
              eol   = 1'b1;
              by_cr = 1'b1;
            end else if (byte_i == hbcd_pkg::ChLf) begin
              eol = 1'b1;
            end else if (byte_i == hbcd_pkg::ChSemi) begin
              nxt.phase = hbcd_pkg::PH_EXT;
            end else if (hv[4] && state_i.digit_cnt < hbcd_pkg::MaxHexDigits) begin
              // Shift in one digit, saturating at the 31-bit maximum.
              if (state_i.size_rem[30:27] != 4'd0) begin
                nxt.size_rem = hbcd_pkg::Max31;
              end else begin
                nxt.size_rem = {state_i.size_rem[26:0], hv[3:0]};
              end
              nxt.digit_cnt = state_i.digit_cnt + 4'd1;
            end
          end
          hbcd_pkg::PH_EXT: begin
            eol = (byte_i == hbcd_pkg::ChLf);
          end
          hbcd_pkg::PH_ERR: begin
            res.status = hbcd_pkg::StSizeErr;
          end
          default: begin
            nxt.done   = 1'b1;
            res.status = hbcd_pkg::StComplete;
          end
        endcase
        // End of a size line.
        if (eol) begin
          if (state_i.digit_cnt == '0) begin
            nxt.phase  = hbcd_pkg::PH_ERR;
            res.status = hbcd_pkg::StSizeErr;
          end else begin
            nxt.digit_cnt = '0;
            if (nxt.size_rem == '0) begin
              nxt.phase  = hbcd_pkg::PH_DONE;
              nxt.done   = 1'b1;
              res.status = hbcd_pkg::StComplete;
            end else begin
              nxt.phase = by_cr ? hbcd_pkg::PH_SIZE_CR : hbcd_pkg::PH_DATA;
            end
          end
        end
      end
    end else if (cfg_i.mode == hbcd_pkg::ModeFixed) begin
      // Fixed content length.
      if (cfg_i.length == '0) begin
        nxt.done   = 1'b1;
        res.status = hbcd_pkg::StNoBody;
      end else if (state_i.bytes_passed < cfg_i.length) begin
        res.payload_valid = 1'b1;
        nxt.bytes_passed  = bp_inc;
        if (bp_inc >= cfg_i.length) begin
          nxt.done   = 1'b1;
          res.status = hbcd_pkg::StComplete;
        end
      end else begin
        nxt.done   = 1'b1;
        res.status = hbcd_pkg::StComplete;
      end
    end else begin
      // Until connection close; bytes beyond the limit are dropped.
      if (state_i.bytes_passed < hbcd_pkg::BodyLimit) begin
        res.payload_valid = 1'b1;
        nxt.bytes_passed  = bp_inc;
      end
    end

    res.payload_byte  = res.payload_valid ? byte_i : '0;
    res.payload_count = nxt.bytes_passed;
    state_o           = nxt;
    result_o          = res;
  end

endmodule
